// ===== sv/tcr_pkg.sv =====
// ----------------------------------------------------------------------------
// tcr_pkg: shared definitions for the text cell renderer
// Cell geometry, panel defaults, command codes, register indexes and the
// 5x7 font table used to build each character cell.
// ----------------------------------------------------------------------------
`default_nettype none

package tcr_pkg;

    // cell and glyph geometry
    localparam int CELL_W  = 6;
    localparam int CELL_H  = 8;
    localparam int GLYPH_W = 5;
    localparam int GLYPH_H = 7;

    // panel size defaults
    localparam int PANEL_W_DEFAULT = 160;
    localparam int PANEL_H_DEFAULT = 80;

    // field widths
    localparam int COL_W    = 8;
    localparam int ROW_W    = 7;
    localparam int CODE_W   = 8;
    localparam int COLOUR_W = 16;
    localparam int KIND_W   = 2;
    localparam int VALUE_W  = 16;
    localparam int OFS_W    = 8;
    localparam int WIN_W    = 9;
    localparam int FONT_IDX_W = 7;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_COLUMN_OFFSET = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_OFFSET    = 2'd1;
    localparam logic [OFS_W-1:0] COLUMN_OFFSET_RESET = 8'd1;
    localparam logic [OFS_W-1:0] ROW_OFFSET_RESET    = 8'd26;

    // printable range and substitute glyph
    localparam logic [CODE_W-1:0] CODE_LO    = 8'h20;
    localparam logic [CODE_W-1:0] CODE_HI    = 8'h7E;
    localparam logic [CODE_W-1:0] CODE_SUBST = 8'h3F;

    // panel commands
    localparam logic [7:0] CMD_COLWIN = 8'h2A;
    localparam logic [7:0] CMD_ROWWIN = 8'h2B;
    localparam logic [7:0] CMD_WRITE  = 8'h2C;

    // beat kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_CMD   = 2'd0,
        KIND_DATA  = 2'd1,
        KIND_PIXEL = 2'd2
    } kind_t;

    // glyph columns, column c in bits [(4-c)*8 +: 8], bit r is glyph row r
    function automatic logic [GLYPH_W*8-1:0] font_rom(input logic [FONT_IDX_W-1:0] idx);
        logic [GLYPH_W*8-1:0] g;
        case (idx)
            7'd0:  g = 40'h0000000000;
            7'd1:  g = 40'h00005F0000;
            7'd2:  g = 40'h0007000700;
            7'd3:  g = 40'h147F147F14;
            7'd4:  g = 40'h242A7F2A12;
            7'd5:  g = 40'h2313086462;
            7'd6:  g = 40'h3649552250;
            7'd7:  g = 40'h0005030000;
            7'd8:  g = 40'h001C224100;
            7'd9:  g = 40'h0041221C00;
            7'd10: g = 40'h14083E0814;
            7'd11: g = 40'h08083E0808;
            7'd12: g = 40'h0050300000;
            7'd13: g = 40'h0808080808;
            7'd14: g = 40'h0060600000;
            7'd15: g = 40'h2010080402;
            7'd16: g = 40'h3E5149453E;
            7'd17: g = 40'h00427F4000;
            7'd18: g = 40'h4261514946;
            7'd19: g = 40'h2141454B31;
            7'd20: g = 40'h1814127F10;
            7'd21: g = 40'h2745454539;
            7'd22: g = 40'h3C4A494930;
            7'd23: g = 40'h0171090503;
            7'd24: g = 40'h3649494936;
            7'd25: g = 40'h064949291E;
            7'd26: g = 40'h0036360000;
            7'd27: g = 40'h0056360000;
            7'd28: g = 40'h0814224100;
            7'd29: g = 40'h1414141414;
            7'd30: g = 40'h0041221408;
            7'd31: g = 40'h0201510906;
            7'd32: g = 40'h324979413E;
            7'd33: g = 40'h7E1111117E;
            7'd34: g = 40'h7F49494936;
            7'd35: g = 40'h3E41414122;
            7'd36: g = 40'h7F4141221C;
            7'd37: g = 40'h7F49494941;
            7'd38: g = 40'h7F09090901;
            7'd39: g = 40'h3E4149497A;
            7'd40: g = 40'h7F0808087F;
            7'd41: g = 40'h00417F4100;
            7'd42: g = 40'h2040413F01;
            7'd43: g = 40'h7F08142241;
            7'd44: g = 40'h7F40404040;
            7'd45: g = 40'h7F020C027F;
            7'd46: g = 40'h7F0408107F;
            7'd47: g = 40'h3E4141413E;
            7'd48: g = 40'h7F09090906;
            7'd49: g = 40'h3E4151215E;
            7'd50: g = 40'h7F09192946;
            7'd51: g = 40'h4649494931;
            7'd52: g = 40'h01017F0101;
            7'd53: g = 40'h3F4040403F;
            7'd54: g = 40'h1F2040201F;
            7'd55: g = 40'h3F4038403F;
            7'd56: g = 40'h6314081463;
            7'd57: g = 40'h0708700807;
            7'd58: g = 40'h6151494543;
            7'd59: g = 40'h007F414100;
            7'd60: g = 40'h0204081020;
            7'd61: g = 40'h0041417F00;
            7'd62: g = 40'h0402010204;
            7'd63: g = 40'h4040404040;
            7'd64: g = 40'h0001020400;
            7'd65: g = 40'h2054545478;
            7'd66: g = 40'h7F48444438;
            7'd67: g = 40'h3844444420;
            7'd68: g = 40'h384444487F;
            7'd69: g = 40'h3854545418;
            7'd70: g = 40'h087E090102;
            7'd71: g = 40'h0C5252523E;
            7'd72: g = 40'h7F08040478;
            7'd73: g = 40'h00447D4000;
            7'd74: g = 40'h2040443D00;
            7'd75: g = 40'h7F10284400;
            7'd76: g = 40'h00417F4000;
            7'd77: g = 40'h7C0418047C;
            7'd78: g = 40'h7C08040478;
            7'd79: g = 40'h3844444438;
            7'd80: g = 40'h7C14141408;
            7'd81: g = 40'h081414187C;
            7'd82: g = 40'h7C08040408;
            7'd83: g = 40'h4854545420;
            7'd84: g = 40'h043F444020;
            7'd85: g = 40'h3C4040207C;
            7'd86: g = 40'h1C2040201C;
            7'd87: g = 40'h3C4030403C;
            7'd88: g = 40'h4428102844;
            7'd89: g = 40'h0C5050503C;
            7'd90: g = 40'h4464544C44;
            7'd91: g = 40'h0008364100;
            7'd92: g = 40'h00007F0000;
            7'd93: g = 40'h0041360800;
            7'd94: g = 40'h1008081008;
            default: g = 40'h0000000000;
        endcase
        return g;
    endfunction

endpackage

`default_nettype wire

// ===== sv/tcr_interfaces.sv =====
// ----------------------------------------------------------------------------
// tcr interfaces: valid/ready channels of the text cell renderer
// Character input channel, command/pixel beat output channel and the
// configuration write channel.
// ----------------------------------------------------------------------------
`default_nettype none

// one character per beat
interface tcr_char_if;
    logic                              valid;
    logic                              ready;
    logic                              first_char;
    logic [tcr_pkg::COL_W-1:0]         start_col;
    logic [tcr_pkg::ROW_W-1:0]         start_row;
    logic [tcr_pkg::CODE_W-1:0]        char_code;
    logic [tcr_pkg::COLOUR_W-1:0]      fg_colour;
    logic [tcr_pkg::COLOUR_W-1:0]      bg_colour;

    modport source (
        output valid, first_char, start_col, start_row, char_code, fg_colour, bg_colour,
        input  ready
    );
    modport sink (
        input  valid, first_char, start_col, start_row, char_code, fg_colour, bg_colour,
        output ready
    );
endinterface

// one command byte, data byte or pixel word per beat
interface tcr_beat_if;
    logic                              valid;
    logic                              ready;
    logic [tcr_pkg::KIND_W-1:0]        kind;
    logic [tcr_pkg::VALUE_W-1:0]       value;
    logic                              last;

    modport source (
        output valid, kind, value, last,
        input  ready
    );
    modport sink (
        input  valid, kind, value, last,
        output ready
    );
endinterface

// register write channel
interface tcr_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [tcr_pkg::CFG_IDX_W-1:0]     index;
    logic [tcr_pkg::CFG_DATA_W-1:0]    data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

`default_nettype wire

// ===== sv/text_cell_renderer_core.sv =====
// ----------------------------------------------------------------------------
// text_cell_renderer_core: 6x8 character cell renderer for an RGB565 panel
// Keeps a text cursor, wraps and stops at the panel edges, and turns each
// character into column/row window commands and 48 pixel words.
// ----------------------------------------------------------------------------
//
//   channel   role     beat contents
//   -------   ------   ---------------------------------------------------
//   chars     sink     first_char, start_col, start_row, char_code, colours
//   stream    source   kind, value, last
//   cfg       sink     index, data (column_offset, row_offset)
//
// a drawn character gives 59 stream beats from the output register, one per cycle
// while stream.ready is high; a new character is taken in the cycle its predecessor's
// last pixel enters that register; a character that draws nothing is taken when the emitter is free
// reset: cursor at 0/0, no string active, offsets 1 and 26, both channels empty
// stream.ready low holds the output register and the beat sequencer; chars then waits
// cfg.ready is always high
`default_nettype none

module text_cell_renderer_core #(
    parameter int PANEL_W = tcr_pkg::PANEL_W_DEFAULT,
    parameter int PANEL_H = tcr_pkg::PANEL_H_DEFAULT
) (
    input  wire         clk,
    input  wire         rst_n,
    tcr_char_if.sink    chars,
    tcr_beat_if.source  stream,
    tcr_cfg_if.sink     cfg
);

    typedef enum logic [3:0] {
        S_COL_CMD, S_COL_X0H, S_COL_X0L, S_COL_X1H, S_COL_X1L,
        S_ROW_CMD, S_ROW_Y0H, S_ROW_Y0L, S_ROW_Y1H, S_ROW_Y1L,
        S_WR_CMD,  S_PIXEL
    } step_t;

    localparam int WIN_W = tcr_pkg::WIN_W;
    localparam int GW    = tcr_pkg::GLYPH_W;
    localparam int GH    = tcr_pkg::GLYPH_H;

    // configuration registers
    logic [tcr_pkg::OFS_W-1:0] column_offset_reg;
    logic [tcr_pkg::OFS_W-1:0] row_offset_reg;

    // cursor state
    logic [tcr_pkg::COL_W-1:0] cursor_col_reg, cursor_col_next;
    logic [tcr_pkg::ROW_W-1:0] cursor_row_reg, cursor_row_next;
    logic                      stopped_reg, stopped_next;

    // active character
    logic                      cur_valid_reg, cur_valid_next;
    step_t                     step_reg, step_next;
    logic [2:0]                pc_reg, pc_next;
    logic [2:0]                pr_reg, pr_next;
    logic [WIN_W-1:0]          x0_reg, x1_reg, y0_reg, y1_reg;
    logic [GW-1:0][GH-1:0]     glyph_reg;
    logic [tcr_pkg::COLOUR_W-1:0] fg_reg, bg_reg;

    // output register
    logic                         stream_valid_reg, stream_valid_next;
    tcr_pkg::kind_t               kind_reg;
    logic [tcr_pkg::VALUE_W-1:0]  value_reg;
    logic                         last_reg;

    // cursor and edge logic for the incoming character
    logic                      accept;
    logic                      active;
    logic [tcr_pkg::COL_W-1:0] base_col;
    logic [tcr_pkg::ROW_W-1:0] base_row;
    logic                      wrap;
    logic [tcr_pkg::COL_W-1:0] col;
    logic [7:0]                row;
    logic                      bottom;
    logic                      draw;
    logic                      take;
    logic [WIN_W-1:0]          x0_in, y0_in;
    logic [tcr_pkg::CODE_W-1:0] code;
    logic [tcr_pkg::FONT_IDX_W-1:0] font_idx;
    logic [GW*8-1:0]           font_bits;
    logic [GW-1:0][GH-1:0]     glyph_in;

    assign accept   = chars.valid && chars.ready;
    assign active   = chars.first_char || !stopped_reg;
    assign base_col = chars.first_char ? chars.start_col : cursor_col_reg;
    assign base_row = chars.first_char ? chars.start_row : cursor_row_reg;
    assign wrap     = ({1'b0, base_col} + 9'(tcr_pkg::CELL_W)) > 9'(PANEL_W);
    assign col      = wrap ? '0 : base_col;
    assign row      = {1'b0, base_row} + (wrap ? 8'(tcr_pkg::CELL_H) : 8'd0);
    assign bottom   = ({1'b0, row} + 9'(tcr_pkg::CELL_H)) > 9'(PANEL_H);
    assign draw     = active && !bottom;
    assign take     = accept && draw;
    assign x0_in    = {1'b0, col} + {1'b0, column_offset_reg};
    assign y0_in    = {1'b0, row} + {1'b0, row_offset_reg};

    // font lookup, out-of-range codes become the substitute glyph
    always_comb
    begin
        code = chars.char_code;
        if (code < tcr_pkg::CODE_LO || code > tcr_pkg::CODE_HI)
        begin
            code = tcr_pkg::CODE_SUBST;
        end
        font_idx  = 7'(code - tcr_pkg::CODE_LO);
        font_bits = tcr_pkg::font_rom(font_idx);
        for (int c = 0; c < GW; c++)
        begin
            glyph_in[c] = font_bits[(GW-1-c)*8 +: GH];
        end
    end

    // cursor next state
    always_comb
    begin
        cursor_col_next = cursor_col_reg;
        cursor_row_next = cursor_row_reg;
        stopped_next    = stopped_reg;
        if (accept && active)
        begin
            if (bottom)
            begin
                cursor_col_next = base_col;
                cursor_row_next = base_row;
                stopped_next    = 1'b1;
            end
            else
            begin
                cursor_col_next = col + 8'(tcr_pkg::CELL_W);
                cursor_row_next = row[tcr_pkg::ROW_W-1:0];
                stopped_next    = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_col_reg <= '0;
            cursor_row_reg <= '0;
            stopped_reg    <= 1'b1;
        end
        else
        begin
            cursor_col_reg <= cursor_col_next;
            cursor_row_reg <= cursor_row_next;
            stopped_reg    <= stopped_next;
        end
    end

    // register writes
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_offset_reg <= tcr_pkg::COLUMN_OFFSET_RESET;
            row_offset_reg    <= tcr_pkg::ROW_OFFSET_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            if (cfg.index == tcr_pkg::REG_COLUMN_OFFSET)
            begin
                column_offset_reg <= cfg.data;
            end
            else if (cfg.index == tcr_pkg::REG_ROW_OFFSET)
            begin
                row_offset_reg <= cfg.data;
            end
        end
    end

    // character payload, loaded when the sequencer starts a new character
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            x0_reg    <= x0_in;
            x1_reg    <= x0_in + 9'(tcr_pkg::CELL_W - 1);
            y0_reg    <= y0_in;
            y1_reg    <= y0_in + 9'(tcr_pkg::CELL_H - 1);
            glyph_reg <= glyph_in;
            fg_reg    <= chars.fg_colour;
            bg_reg    <= chars.bg_colour;
        end
    end

    // beat selection for the current step
    logic                        out_load;
    logic                        beat_last;
    logic                        pix_on;
    logic [GH:0]                 glyph_col;
    tcr_pkg::kind_t              beat_kind;
    logic [tcr_pkg::VALUE_W-1:0] beat_value;

    assign out_load  = cur_valid_reg && (!stream_valid_reg || stream.ready);
    assign beat_last = (step_reg == S_PIXEL) && (pr_reg == 3'(tcr_pkg::CELL_H - 1))
                       && (pc_reg == 3'(tcr_pkg::CELL_W - 1));
    assign chars.ready = !cur_valid_reg || (out_load && beat_last);

    always_comb
    begin
        // padding column and padding row read as clear
        glyph_col = '0;
        if (pc_reg < 3'(GW))
        begin
            glyph_col = {1'b0, glyph_reg[pc_reg]};
        end
        pix_on = glyph_col[pr_reg];

        beat_kind  = tcr_pkg::KIND_DATA;
        beat_value = '0;
        case (step_reg)
            S_COL_CMD:
            begin
                beat_kind  = tcr_pkg::KIND_CMD;
                beat_value = {8'h00, tcr_pkg::CMD_COLWIN};
            end
            S_COL_X0H: beat_value = {15'h0000, x0_reg[WIN_W-1]};
            S_COL_X0L: beat_value = {8'h00, x0_reg[7:0]};
            S_COL_X1H: beat_value = {15'h0000, x1_reg[WIN_W-1]};
            S_COL_X1L: beat_value = {8'h00, x1_reg[7:0]};
            S_ROW_CMD:
            begin
                beat_kind  = tcr_pkg::KIND_CMD;
                beat_value = {8'h00, tcr_pkg::CMD_ROWWIN};
            end
            S_ROW_Y0H: beat_value = {15'h0000, y0_reg[WIN_W-1]};
            S_ROW_Y0L: beat_value = {8'h00, y0_reg[7:0]};
            S_ROW_Y1H: beat_value = {15'h0000, y1_reg[WIN_W-1]};
            S_ROW_Y1L: beat_value = {8'h00, y1_reg[7:0]};
            S_WR_CMD:
            begin
                beat_kind  = tcr_pkg::KIND_CMD;
                beat_value = {8'h00, tcr_pkg::CMD_WRITE};
            end
            S_PIXEL:
            begin
                beat_kind  = tcr_pkg::KIND_PIXEL;
                beat_value = pix_on ? fg_reg : bg_reg;
            end
            default:
            begin
                beat_kind  = tcr_pkg::KIND_CMD;
                beat_value = '0;
            end
        endcase
    end

    // sequencer next state
    always_comb
    begin
        cur_valid_next    = cur_valid_reg;
        step_next         = step_reg;
        pc_next           = pc_reg;
        pr_next           = pr_reg;
        stream_valid_next = stream_valid_reg;

        if (stream.ready)
        begin
            stream_valid_next = 1'b0;
        end
        if (out_load)
        begin
            stream_valid_next = 1'b1;
            if (step_reg != S_PIXEL)
            begin
                step_next = step_t'(step_reg + 4'd1);
            end
            else if (pc_reg == 3'(tcr_pkg::CELL_W - 1))
            begin
                pc_next = '0;
                pr_next = pr_reg + 3'd1;
            end
            else
            begin
                pc_next = pc_reg + 3'd1;
            end
            if (beat_last)
            begin
                cur_valid_next = 1'b0;
            end
        end
        if (take)
        begin
            cur_valid_next = 1'b1;
            step_next      = S_COL_CMD;
            pc_next        = '0;
            pr_next        = '0;
        end
    end

    // sequencer state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg    <= 1'b0;
            step_reg         <= S_COL_CMD;
            pc_reg           <= '0;
            pr_reg           <= '0;
            stream_valid_reg <= 1'b0;
            kind_reg         <= tcr_pkg::KIND_CMD;
            value_reg        <= '0;
            last_reg         <= 1'b0;
        end
        else
        begin
            cur_valid_reg    <= cur_valid_next;
            step_reg         <= step_next;
            pc_reg           <= pc_next;
            pr_reg           <= pr_next;
            stream_valid_reg <= stream_valid_next;
            if (out_load)
            begin
                kind_reg  <= beat_kind;
                value_reg <= beat_value;
                last_reg  <= beat_last;
            end
        end
    end

    assign stream.valid = stream_valid_reg;
    assign stream.kind  = kind_reg;
    assign stream.value = value_reg;
    assign stream.last  = last_reg;

    // a character is only taken over a busy sequencer on its final pixel
    a_take_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cur_valid_reg) |-> (out_load && beat_last))
        else $error("character taken while sequencer busy");

    // when the sequencer goes idle the final pixel sits in the output register
    a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(cur_valid_reg) |-> (stream_valid_reg && last_reg
                                  && kind_reg == tcr_pkg::KIND_PIXEL))
        else $error("sequencer idle without final pixel");

    // pixel counters stay inside the cell
    a_pixel_range: assert property (@(posedge clk) disable iff (!rst_n)
        cur_valid_reg |-> ({1'b0, pc_reg} < 4'(tcr_pkg::CELL_W)
                           && {1'b0, pr_reg} < 4'(tcr_pkg::CELL_H)))
        else $error("pixel counter out of cell");

endmodule

`default_nettype wire

// ===== bench/text_cell_renderer_core_tb.sv =====
// ----------------------------------------------------------------------------
// text_cell_renderer_core_tb: self-checking bench for the text cell renderer
// Feeds strings of characters through the char channel and compares every
// command, data and pixel beat against a cycle-free model of the cursor, edge
// handling, window bytes and font cells. Runs a directed part at reset offsets,
// then random strings under several offset settings with bursty input and a
// stalling receiver.
// ----------------------------------------------------------------------------
`default_nettype none

module text_cell_renderer_core_tb;

    localparam int PANEL_W      = tcr_pkg::PANEL_W_DEFAULT;
    localparam int PANEL_H      = tcr_pkg::PANEL_H_DEFAULT;
    localparam int LIMIT        = 1000000;
    localparam int HOLD_CYCLES  = 400;
    localparam int IDLE_PAUSE   = 8;
    localparam int RANDOM_ITEMS = 360;
    localparam int CHUNK_ITEMS  = 60;

    // glyph columns, column c in bits [(4-c)*8 +: 8], bit r is row r
    localparam logic [39:0] FONT [95] = '{
        40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
        40'h242A7F2A12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
        40'h001C224100, 40'h0041221C00, 40'h14083E0814, 40'h08083E0808,
        40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
        40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
        40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
        40'h3649494936, 40'h064949291E, 40'h0036360000, 40'h0056360000,
        40'h0814224100, 40'h1414141414, 40'h0041221408, 40'h0201510906,
        40'h324979413E, 40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
        40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h3E4149497A,
        40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
        40'h7F40404040, 40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E,
        40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931,
        40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h3F4038403F,
        40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007F414100,
        40'h0204081020, 40'h0041417F00, 40'h0402010204, 40'h4040404040,
        40'h0001020400, 40'h2054545478, 40'h7F48444438, 40'h3844444420,
        40'h384444487F, 40'h3854545418, 40'h087E090102, 40'h0C5252523E,
        40'h7F08040478, 40'h00447D4000, 40'h2040443D00, 40'h7F10284400,
        40'h00417F4000, 40'h7C0418047C, 40'h7C08040478, 40'h3844444438,
        40'h7C14141408, 40'h081414187C, 40'h7C08040408, 40'h4854545420,
        40'h043F444020, 40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C,
        40'h4428102844, 40'h0C5050503C, 40'h4464544C44, 40'h0008364100,
        40'h00007F0000, 40'h0041360800, 40'h1008081008
    };

    typedef struct {
        logic                         first_char;
        logic [tcr_pkg::COL_W-1:0]    start_col;
        logic [tcr_pkg::ROW_W-1:0]    start_row;
        logic [tcr_pkg::CODE_W-1:0]   char_code;
        logic [tcr_pkg::COLOUR_W-1:0] fg_colour;
        logic [tcr_pkg::COLOUR_W-1:0] bg_colour;
    } cell_req_t;

    typedef struct {
        tcr_pkg::kind_t              kind;
        logic [tcr_pkg::VALUE_W-1:0] value;
        logic                        last;
    } panel_beat_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    tcr_char_if chars_if ();
    tcr_beat_if beat_if ();
    tcr_cfg_if  cfg_if ();

    text_cell_renderer_core u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .chars  (chars_if),
        .stream (beat_if),
        .cfg    (cfg_if)
    );

    // model state: cursor, string status and panel offsets
    logic [tcr_pkg::COL_W-1:0] cur_col = '0;
    logic [tcr_pkg::ROW_W-1:0] cur_row = '0;
    logic                      halted  = 1'b1;
    logic [tcr_pkg::OFS_W-1:0] col_ofs = tcr_pkg::COLUMN_OFFSET_RESET;
    logic [tcr_pkg::OFS_W-1:0] row_ofs = tcr_pkg::ROW_OFFSET_RESET;

    cell_req_t   pending_chars[$];
    panel_beat_t panel_beats_due[$];

    int chars_queued   = 0;
    int chars_accepted = 0;
    int mismatches     = 0;
    int cycle_count    = 0;

    // sender burst state
    int burst_left = 0;
    int gap_left   = 0;

    // receiver stall state
    int   stall_mode = 0;
    int   mode_left  = 0;
    int   tick       = 0;
    logic take;
    logic hold_kick = 1'b0;
    logic hold_seen = 1'b0;
    int   hold_left = 0;

    always #5 clk = ~clk;

    task automatic report_mismatch(input string what);
        $display("cycle %0d: mismatch: %s", cycle_count, what);
        mismatches++;
    endtask

    task automatic push_beat(input tcr_pkg::kind_t k, input logic [tcr_pkg::VALUE_W-1:0] v,
                             input logic l);
        panel_beat_t b;
        b.kind  = k;
        b.value = v;
        b.last  = l;
        panel_beats_due.push_back(b);
    endtask

    // command then both window bounds, high byte first
    task automatic push_window(input logic [7:0] cmd, input int lo, input int hi);
        push_beat(tcr_pkg::KIND_CMD, {8'h00, cmd}, 1'b0);
        push_beat(tcr_pkg::KIND_DATA, 16'((lo >> 8) & 'hFF), 1'b0);
        push_beat(tcr_pkg::KIND_DATA, 16'(lo & 'hFF), 1'b0);
        push_beat(tcr_pkg::KIND_DATA, 16'((hi >> 8) & 'hFF), 1'b0);
        push_beat(tcr_pkg::KIND_DATA, 16'(hi & 'hFF), 1'b0);
    endtask

    // cursor and edge rules, then the expected beats of one cell
    task automatic draw_cell(input cell_req_t ch);
        int          col;
        int          row;
        int          x0;
        int          y0;
        logic [7:0]  code;
        logic [39:0] glyph;
        logic        on;
        if (ch.first_char)
        begin
            cur_col = ch.start_col;
            cur_row = ch.start_row;
            halted  = 1'b0;
        end
        if (halted)
            return;
        col = cur_col;
        row = cur_row;
        if (col + tcr_pkg::CELL_W > PANEL_W)
        begin
            col = 0;
            row += tcr_pkg::CELL_H;
        end
        if (row + tcr_pkg::CELL_H > PANEL_H)
        begin
            halted = 1'b1;
            return;
        end
        code = ch.char_code;
        if (code < tcr_pkg::CODE_LO || code > tcr_pkg::CODE_HI)
            code = tcr_pkg::CODE_SUBST;
        glyph = FONT[code - tcr_pkg::CODE_LO];
        x0 = col + col_ofs;
        y0 = row + row_ofs;
        push_window(tcr_pkg::CMD_COLWIN, x0, x0 + tcr_pkg::CELL_W - 1);
        push_window(tcr_pkg::CMD_ROWWIN, y0, y0 + tcr_pkg::CELL_H - 1);
        push_beat(tcr_pkg::KIND_CMD, {8'h00, tcr_pkg::CMD_WRITE}, 1'b0);
        for (int r = 0; r < tcr_pkg::CELL_H; r++)
        begin
            for (int c = 0; c < tcr_pkg::CELL_W; c++)
            begin
                on = (c < tcr_pkg::GLYPH_W) && (r < tcr_pkg::GLYPH_H)
                     && glyph[(4 - c) * 8 + r];
                push_beat(tcr_pkg::KIND_PIXEL, on ? ch.fg_colour : ch.bg_colour,
                          (r == tcr_pkg::CELL_H - 1) && (c == tcr_pkg::CELL_W - 1));
            end
        end
        cur_col = 8'(col + tcr_pkg::CELL_W);
        cur_row = 7'(row);
    endtask

    task automatic queue_char(input logic first, input logic [7:0] scol, input logic [6:0] srow,
                              input logic [7:0] code, input logic [15:0] fg,
                              input logic [15:0] bg);
        cell_req_t ch;
        ch.first_char = first;
        ch.start_col  = scol;
        ch.start_row  = srow;
        ch.char_code  = code;
        ch.fg_colour  = fg;
        ch.bg_colour  = bg;
        pending_chars.push_back(ch);
        chars_queued++;
    endtask

    function automatic logic [15:0] rand_colour();
        int pick;
        pick = $urandom_range(0, 7);
        if (pick == 0)
            return 16'h0000;
        if (pick == 1)
            return 16'hFFFF;
        return 16'($urandom_range(0, 65535));
    endfunction

    // mostly printable, the rest anywhere in the byte
    function automatic logic [7:0] rand_code();
        if ($urandom_range(0, 4) != 0)
            return 8'($urandom_range(tcr_pkg::CODE_LO, tcr_pkg::CODE_HI));
        return 8'($urandom_range(0, 255));
    endfunction

    // random strings: mostly in the panel, some near the bottom right, some anywhere
    task automatic queue_strings(input int n_items);
        int         left;
        int         len;
        int         pick;
        logic [7:0] scol;
        logic [6:0] srow;
        left = n_items;
        while (left > 0)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 5)
            begin
                queue_char(1'b0, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)),
                           rand_code(), rand_colour(), rand_colour());
                left--;
            end
            else
            begin
                if (pick < 15)
                begin
                    scol = 8'($urandom_range(0, 255));
                    srow = 7'($urandom_range(0, 127));
                end
                else if (pick < 35)
                begin
                    scol = 8'($urandom_range(120, 159));
                    srow = 7'($urandom_range(56, 79));
                end
                else
                begin
                    scol = 8'($urandom_range(0, 159));
                    srow = 7'($urandom_range(0, 71));
                end
                len = $urandom_range(1, 24);
                queue_char(1'b1, scol, srow, rand_code(), rand_colour(), rand_colour());
                for (int i = 1; i < len; i++)
                    queue_char(1'b0, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)),
                               rand_code(), rand_colour(), rand_colour());
                left -= len;
            end
        end
    endtask

    // all characters taken, all beats seen, then a short settle
    task automatic wait_idle();
        while (chars_accepted != chars_queued || panel_beats_due.size() != 0)
            @(posedge clk);
        repeat (IDLE_PAUSE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [tcr_pkg::CFG_IDX_W-1:0] idx,
                             input logic [tcr_pkg::CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        if (idx == tcr_pkg::REG_COLUMN_OFFSET)
            col_ofs = val;
        else
            row_ofs = val;
    endtask

    // character sender: bursts of random length with random gaps
    always @(posedge clk)
    begin
        cell_req_t nxt;
        if (rst_n && (!chars_if.valid || chars_if.ready))
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                chars_if.valid <= 1'b0;
            end
            else if (pending_chars.size() != 0)
            begin
                nxt = pending_chars.pop_front();
                chars_if.valid      <= 1'b1;
                chars_if.first_char <= nxt.first_char;
                chars_if.start_col  <= nxt.start_col;
                chars_if.start_row  <= nxt.start_row;
                chars_if.char_code  <= nxt.char_code;
                chars_if.fg_colour  <= nxt.fg_colour;
                chars_if.bg_colour  <= nxt.bg_colour;
                if (burst_left > 0)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(0, 15);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
                end
            end
            else
                chars_if.valid <= 1'b0;
        end
    end

    // long receiver hold-off, started by a toggle of hold_kick
    always @(posedge clk)
    begin
        if (hold_kick != hold_seen)
        begin
            hold_seen <= hold_kick;
            hold_left <= HOLD_CYCLES;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // receiver stall pattern: free running, random, light random, periodic from a tick counter
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (mode_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                mode_left  = $urandom_range(50, 300);
            end
            else
                mode_left--;
            case (stall_mode)
                0: take = 1'b1;
                1: take = 1'($urandom_range(0, 1));
                2: take = ($urandom_range(0, 9) != 0);
                default:
                begin
                    tick = (tick == 2) ? 0 : tick + 1;
                    take = (tick == 0);
                end
            endcase
            beat_if.ready <= take && (hold_left == 0);
        end
    end

    // accepted characters feed the model, accepted beats are checked in order
    always @(posedge clk)
    begin
        panel_beat_t due;
        if (rst_n)
        begin
            if (chars_if.valid && chars_if.ready)
            begin
                draw_cell('{chars_if.first_char, chars_if.start_col, chars_if.start_row,
                            chars_if.char_code, chars_if.fg_colour, chars_if.bg_colour});
                chars_accepted++;
            end
            if (beat_if.valid && beat_if.ready)
            begin
                if (panel_beats_due.size() == 0)
                    report_mismatch($sformatf("beat kind %0d value %h last %b with none expected",
                                              beat_if.kind, beat_if.value, beat_if.last));
                else
                begin
                    due = panel_beats_due.pop_front();
                    if (beat_if.kind !== due.kind || beat_if.value !== due.value ||
                        beat_if.last !== due.last)
                        report_mismatch($sformatf("got kind %0d value %h last %b, want %0d %h %b",
                                                  beat_if.kind, beat_if.value, beat_if.last,
                                                  due.kind, due.value, due.last));
                end
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        int phase;
        int random_base;
        chars_if.valid      = 1'b0;
        chars_if.first_char = 1'b0;
        chars_if.start_col  = '0;
        chars_if.start_row  = '0;
        chars_if.char_code  = '0;
        chars_if.fg_colour  = '0;
        chars_if.bg_colour  = '0;
        beat_if.ready       = 1'b0;
        cfg_if.valid        = 1'b0;
        cfg_if.index        = tcr_pkg::REG_COLUMN_OFFSET;
        cfg_if.data         = '0;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed part at reset offsets
        queue_char(1'b0, 8'd0, 7'd0, 8'h41, 16'h1234, 16'h4321);     // no string yet
        queue_char(1'b1, 8'd0, 7'd0, 8'h20, 16'hFFFF, 16'h0000);     // lowest printable
        queue_char(1'b0, 8'd0, 7'd0, 8'h7E, 16'h0000, 16'hFFFF);     // highest printable
        queue_char(1'b0, 8'd0, 7'd0, 8'h00, 16'hFFFF, 16'h0000);     // out of set
        queue_char(1'b0, 8'd0, 7'd0, 8'h1F, 16'hF800, 16'h07E0);
        queue_char(1'b0, 8'd0, 7'd0, 8'h7F, 16'h001F, 16'hFFE0);
        queue_char(1'b0, 8'd0, 7'd0, 8'hFF, 16'hFFFF, 16'h0000);
        queue_char(1'b0, 8'd0, 7'd0, 8'h41, 16'hFFFF, 16'h0000);
        queue_char(1'b1, 8'd154, 7'd0, 8'h57, 16'hAAAA, 16'h5555); // last cell on the row
        queue_char(1'b0, 8'd0, 7'd0, 8'h31, 16'h5555, 16'hAAAA);     // wraps
        queue_char(1'b1, 8'd155, 7'd10, 8'h78, 16'hFFFF, 16'h0000); // wraps at once
        queue_char(1'b1, 8'd150, 7'd72, 8'h67, 16'hFFFF, 16'h0000); // bottom row
        queue_char(1'b0, 8'd0, 7'd0, 8'h68, 16'hFFFF, 16'h0000);     // wrap past the bottom
        queue_char(1'b0, 8'd0, 7'd0, 8'h69, 16'hFFFF, 16'h0000);     // dropped
        queue_char(1'b1, 8'd0, 7'd73, 8'h6A, 16'hFFFF, 16'h0000);   // below the bottom
        queue_char(1'b1, 8'd255, 7'd127, 8'h6B, 16'hFFFF, 16'h0000); // far outside
        queue_char(1'b1, 8'd0, 7'd72, 8'h40, 16'h0000, 16'hFFFF);
        queue_char(1'b0, 8'd0, 7'd0, 8'h23, 16'h0000, 16'hFFFF);
        queue_char(1'b1, 8'd100, 7'd40, 8'h80, 16'hAAAA, 16'h5555);
        queue_char(1'b0, 8'd0, 7'd0, 8'h5A, 16'h5555, 16'hAAAA);
        queue_char(1'b1, 8'd159, 7'd79, 8'h42, 16'hFFFF, 16'h0000); // wrap then stop
        queue_char(1'b1, 8'd200, 7'd0, 8'h43, 16'hFFFF, 16'h0000);  // wide start wraps
        wait_idle();

        // random strings over several offset settings
        random_base = chars_queued;
        phase = 0;
        while (chars_queued - random_base < RANDOM_ITEMS)
        begin
            case (phase % 5)
                0:
                begin
                    write_reg(tcr_pkg::REG_COLUMN_OFFSET, 8'd0);
                    write_reg(tcr_pkg::REG_ROW_OFFSET, 8'd0);
                end
                1:
                begin
                    write_reg(tcr_pkg::REG_COLUMN_OFFSET, 8'd255);
                    write_reg(tcr_pkg::REG_ROW_OFFSET, 8'd255);
                end
                2:
                begin
                    write_reg(tcr_pkg::REG_COLUMN_OFFSET, 8'($urandom_range(0, 255)));
                    write_reg(tcr_pkg::REG_ROW_OFFSET, 8'($urandom_range(0, 255)));
                end
                3:
                begin
                    write_reg(tcr_pkg::REG_COLUMN_OFFSET, tcr_pkg::COLUMN_OFFSET_RESET);
                    write_reg(tcr_pkg::REG_ROW_OFFSET, tcr_pkg::ROW_OFFSET_RESET);
                end
                default:
                begin
                    write_reg(tcr_pkg::REG_COLUMN_OFFSET, 8'd0);
                    write_reg(tcr_pkg::REG_ROW_OFFSET, 8'd255);
                end
            endcase
            queue_strings(CHUNK_ITEMS);
            // receiver holds off while the sender keeps offering
            if (phase % 5 == 1 || phase % 5 == 4)
                hold_kick <= ~hold_kick;
            wait_idle();
            phase++;
        end

        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire

// ===== text_cell_renderer_core.f =====
sv/tcr_pkg.sv
sv/tcr_interfaces.sv
sv/text_cell_renderer_core.sv
bench/text_cell_renderer_core_tb.sv
